/* src/bw_pkg.sv */
// Shared types and constants for the blind wipe strip sequencer.
// No dependencies; imported by every module of the block.
package bw_pkg;

    localparam int COORD_W  = 12;
    localparam int STEP_W   = 8;
    localparam int OFF_W    = 13;
    localparam int DEST_W   = 14;
    localparam int TICK_W   = 15;
    localparam int START_W  = 16;
    localparam int CIDX_W   = 3;
    localparam int START_SHIFT = 4;

    localparam logic [TICK_W-1:0]  TICK_MAX  = 15'h7fff;
    localparam logic [START_W-1:0] START_SAT = 16'h8000;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_STRIP_PITCH  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_GROW_STEP    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_TICK_STEP    = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic               alive;
    } cell_t;

    typedef struct packed {
        logic [COORD_W-1:0] image_width;
        logic [COORD_W-1:0] image_height;
        logic [COORD_W-1:0] strip_pitch;
        logic [STEP_W-1:0]  grow_step;
        logic [STEP_W-1:0]  tick_step;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_CLEAR,
        OP_GROW
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESTART,
        ST_TICK
    } st_t;

endpackage

/* src/blind_wipe_strip_sequencer_core.sv */
// Top level of the blind wipe strip sequencer: control, config registers,
// cell ring and output register. Depends on bw_pkg, bw_cell, bw_strip_unit.
//
//  channel  handshake            payload
//  -------  -------------------  --------------------------------------------
//  in       in_valid/in_ready    kind, dest_offset
//  out      out_valid/out_ready  src_x, dest_x, copy_width, copy_height,
//                                last, strips_left
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item is accepted while idle, then the strip cells rotate once through the
// shared strip unit, one strip per cycle except while a tick command waits on a
// full output register; a new item is not accepted until the walk is done.
// A restart walk also counts the strips; a tick emits one command per strip.
// Reset loads the strip cells directly, no clearing pass.
// A full output register lets the walk go on only past strips that emit nothing.
module blind_wipe_strip_sequencer_core
    import bw_pkg::*;
#(
    parameter int MAX_STRIPS = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [OFF_W-1:0]            dest_offset,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_W-1:0]          src_x,
    output logic [DEST_W-1:0]           dest_x,
    output logic [COORD_W-1:0]          copy_width,
    output logic [COORD_W-1:0]          copy_height,
    output logic                        last,
    output logic [$clog2(MAX_STRIPS+1)-1:0] strips_left,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CIDX_W-1:0]           cfg_index,
    input  logic [COORD_W-1:0]          cfg_data
);

    localparam int IDX_W = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
    localparam int CNT_W = $clog2(MAX_STRIPS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_STRIPS - 1);

    st_t                 state_reg, state_next;
    cfg_t                cfg_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [START_W-1:0]  start_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    fin_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [OFF_W-1:0]    off_reg;

    logic                out_valid_reg;
    logic [COORD_W-1:0]  src_x_reg;
    logic [DEST_W-1:0]   dest_x_reg;
    logic [COORD_W-1:0]  copy_width_reg;
    logic [COORD_W-1:0]  copy_height_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    strips_left_reg;

    op_t                 op;
    logic                in_range;
    logic                emit;
    logic                step_go;
    logic                at_end;
    logic                is_last;
    logic                x_inside;
    logic [CNT_W-1:0]    fin_now;
    logic [TICK_W:0]     tick_sum;

    cell_t               chain_q [MAX_STRIPS];
    cell_t               tail;
    logic                finish;
    logic [COORD_W-1:0]  x_next;
    logic [START_W-1:0]  start_next;
    logic [DEST_W-1:0]   unit_dest_x;

    // strip ring: cell 0 is the head, the strip unit refills the far end
    for (genvar k = 0; k < MAX_STRIPS; k++)
    begin : g_cell
        cell_t d;
        if (k == MAX_STRIPS - 1)
        begin : g_tail
            assign d = tail;
        end
        else
        begin : g_mid
            assign d = chain_q[k+1];
        end
        bw_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (step_go),
            .d     (d),
            .q     (chain_q[k])
        );
    end

    bw_strip_unit u_unit (
        .op         (op),
        .cfg        (cfg_reg),
        .head       (chain_q[0]),
        .x          (x_reg),
        .start_at   (start_reg),
        .tick_count (tick_reg),
        .offset     (off_reg),
        .tail       (tail),
        .finish     (finish),
        .x_next     (x_next),
        .start_next (start_next),
        .dest_x     (unit_dest_x)
    );

    always_comb
    begin
        in_range = CNT_W'(idx_reg) < total_reg;
        at_end   = idx_reg == LAST_IDX;
        is_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == total_reg;
        x_inside = x_reg < cfg_reg.image_width;
        fin_now  = fin_reg + CNT_W'(finish);
        tick_sum = {1'b0, tick_reg} + (TICK_W + 1)'(cfg_reg.tick_step);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kind ? ST_TICK : ST_RESTART;
                end
            end
            ST_RESTART, ST_TICK:
            begin
                if (step_go && at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        op       = OP_PASS;
        emit     = 1'b0;
        step_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE:    in_ready = 1'b1;
            ST_RESTART:
            begin
                op      = OP_CLEAR;
                step_go = 1'b1;
            end
            ST_TICK:
            begin
                emit    = in_range;
                op      = in_range ? OP_GROW : OP_PASS;
                step_go = !(in_range && out_valid_reg && !out_ready);
            end
            default:    in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            x_reg     <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
            fin_reg   <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
            begin
                idx_reg   <= '0;
                x_reg     <= '0;
                start_reg <= '0;
                cnt_reg   <= '0;
            end
            else if (step_go)
            begin
                idx_reg   <= idx_reg + IDX_W'(1);
                x_reg     <= x_next;
                start_reg <= start_next;
                if (state_reg == ST_RESTART)
                begin
                    // strip i exists while its left edge lies inside the image
                    cnt_reg <= cnt_reg + CNT_W'(x_inside);
                    if (at_end)
                    begin
                        total_reg <= cnt_reg + CNT_W'(x_inside);
                        fin_reg   <= '0;
                        tick_reg  <= '0;
                    end
                end
                else
                begin
                    if (emit)
                    begin
                        fin_reg <= fin_now;
                    end
                    if (at_end)
                    begin
                        tick_reg <= (tick_sum > {1'b0, TICK_MAX}) ? TICK_MAX
                                                                 : tick_sum[TICK_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            off_reg <= dest_offset;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 12'd640;
            cfg_reg.image_height <= 12'd480;
            cfg_reg.strip_pitch  <= 12'd32;
            cfg_reg.grow_step    <= 8'd1;
            cfg_reg.tick_step    <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_STRIP_PITCH:  cfg_reg.strip_pitch  <= cfg_data;
                REG_GROW_STEP:    cfg_reg.grow_step    <= cfg_data[STEP_W-1:0];
                REG_TICK_STEP:    cfg_reg.tick_step    <= cfg_data[STEP_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && step_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && step_go)
        begin
            src_x_reg       <= x_reg;
            dest_x_reg      <= unit_dest_x;
            copy_width_reg  <= chain_q[0].width;
            copy_height_reg <= cfg_reg.image_height;
            last_reg        <= is_last;
            strips_left_reg <= is_last ? (total_reg - fin_now) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign src_x       = src_x_reg;
    assign dest_x      = dest_x_reg;
    assign copy_width  = copy_width_reg;
    assign copy_height = copy_height_reg;
    assign last        = last_reg;
    assign strips_left = strips_left_reg;

    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg <= total_reg)
        else $error("finished count exceeds strip total");

    a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_valid_reg && !out_ready) |=> $stable(idx_reg))
        else $error("strip walk moved while command stalled");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start a walk");

    a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (strips_left == '0))
        else $error("strips left set on a command that is not the last");

endmodule

/* src/bw_cell.sv */
// One strip cell of the ring: holds a strip's width and alive flag.
// Depends on bw_pkg for cell_t.
module bw_cell
    import bw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  cell_t d,
    output cell_t q
);

    cell_t cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.width <= '0;
            cell_reg.alive <= 1'b1;
        end
        else if (shift)
        begin
            cell_reg <= d;
        end
    end

    assign q = cell_reg;

endmodule

/* src/bw_strip_unit.sv */
// Shared per-strip logic: clearing, growth, finish detection and the copy command
// for the cell at the head of the ring. Depends on bw_pkg.
module bw_strip_unit
    import bw_pkg::*;
(
    input  op_t                  op,
    input  cfg_t                 cfg,
    input  cell_t                head,
    input  logic [COORD_W-1:0]   x,
    input  logic [START_W-1:0]   start_at,
    input  logic [TICK_W-1:0]    tick_count,
    input  logic [OFF_W-1:0]     offset,
    output cell_t                tail,
    output logic                 finish,
    output logic [COORD_W-1:0]   x_next,
    output logic [START_W-1:0]   start_next,
    output logic [DEST_W-1:0]    dest_x
);

    logic [COORD_W-1:0] pitch;
    logic [COORD_W:0]   end_sum;
    logic [COORD_W-1:0] strip_end;
    logic signed [DEST_W-1:0] goal;
    logic [COORD_W:0]   x_plus_w;
    logic               grow_ok;
    logic               started;
    logic [START_W:0]   start_sum;

    always_comb
    begin
        pitch     = (cfg.strip_pitch == '0) ? COORD_W'(1) : cfg.strip_pitch;
        end_sum   = {1'b0, x} + {1'b0, pitch};
        strip_end = (end_sum > {1'b0, cfg.image_width}) ? cfg.image_width
                                                        : end_sum[COORD_W-1:0];
        goal      = $signed({2'b00, strip_end}) - $signed({6'b0, cfg.grow_step})
                    + $signed(DEST_W'(1));
        x_plus_w  = {1'b0, x} + {1'b0, head.width};
        grow_ok   = $signed({1'b0, x_plus_w}) < goal;
        started   = {1'b0, tick_count} >= start_at;
        start_sum = {1'b0, start_at} + (START_W + 1)'(pitch >> START_SHIFT);
        x_next    = strip_end;
        start_next = (start_sum > {1'b0, START_SAT}) ? START_SAT
                                                     : start_sum[START_W-1:0];
        dest_x    = {offset[OFF_W-1], offset} + {2'b00, x};
    end

    always_comb
    begin
        tail   = head;
        finish = 1'b0;
        unique case (op)
            OP_PASS:  tail = head;
            OP_CLEAR:
            begin
                tail.width = '0;
                tail.alive = 1'b1;
            end
            OP_GROW:
            begin
                if (started)
                begin
                    if (grow_ok)
                    begin
                        tail.width = head.width + {4'b0, cfg.grow_step};
                    end
                    else if (head.alive)
                    begin
                        tail.alive = 1'b0;
                        finish     = 1'b1;
                    end
                end
            end
            default:  tail = head;
        endcase
    end

endmodule
